>>> hdl/yuv2rgb_pkg.sv
// shared constants and types for the yuv to rgb pixel converter
package yuv2rgb_pkg;

  // chroma term lanes
  localparam int LANES      = 4;
  localparam int LANE_RED   = 0;
  localparam int LANE_GV    = 1;
  localparam int LANE_GU    = 2;
  localparam int LANE_BLUE  = 3;

  // reciprocal scaling for the constant divides
  localparam int RECIP_SHIFT = 24;
  localparam int QUOT_W      = 8;
  localparam int PROD_W      = 17;
  localparam int RECIP_W     = 16;

  // ratio numerators, denominators and scaled reciprocals per lane
  localparam logic [9:0] TERM_NUM [LANES] = '{10'd419, 10'd299, 10'd114, 10'd587};
  localparam logic [8:0] TERM_DEN [LANES] = '{9'd299, 9'd419, 9'd331, 9'd331};
  localparam logic [RECIP_W-1:0] TERM_RECIP [LANES] = '{
    RECIP_W'((1 << RECIP_SHIFT) / 299),
    RECIP_W'((1 << RECIP_SHIFT) / 419),
    RECIP_W'((1 << RECIP_SHIFT) / 331),
    RECIP_W'((1 << RECIP_SHIFT) / 331)
  };

  localparam logic [7:0] CHROMA_OFFSET = 8'd128;
  localparam logic [7:0] PIX_MAX       = 8'd255;
  localparam logic [7:0] MASK_R5       = 8'hf8;
  localparam logic [7:0] MASK_G6       = 8'hfc;

  // output format codes and byte counts
  localparam logic [1:0] FMT_XRGB32 = 2'd0;
  localparam logic [1:0] FMT_RGB24  = 2'd1;
  localparam logic [1:0] FMT_RGB565 = 2'd2;

  localparam logic [2:0] BYTES_XRGB32 = 3'd4;
  localparam logic [2:0] BYTES_RGB24  = 3'd3;
  localparam logic [2:0] BYTES_RGB565 = 3'd2;

  typedef logic signed [8:0] term_t;

  // luma plus the four signed chroma terms
  typedef struct packed {
    logic [7:0]              luma;
    term_t [LANES-1:0]       term;
  } terms_t;

endpackage

>>> hdl/yuv2rgb_ifs.sv
// handshake channel interfaces for pixels in, pixels out and configuration

interface yuv2rgb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic [7:0] chroma_blue;
  logic [7:0] chroma_red;

  modport source (output valid, output luma, output chroma_blue, output chroma_red,
                  input ready);
  modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                  output ready);
endinterface

interface yuv2rgb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [31:0] pixel_word;
  logic [2:0]  byte_count;

  modport source (output valid, output red, output green, output blue,
                  output pixel_word, output byte_count, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input pixel_word, input byte_count, output ready);
endinterface

interface yuv2rgb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_format;

  modport source (output valid, output out_format, input ready);
  modport sink   (input valid, input out_format, output ready);
endinterface

>>> hdl/yuv2rgb_chroma.sv
// three-stage chroma term pipeline: constant multiply, reciprocal divide, correction
module yuv2rgb_chroma
  import yuv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  logic [7:0] luma,
  input  logic [7:0] chroma_blue,
  input  logic [7:0] chroma_red,
  output logic       dn_valid,
  input  logic       dn_ready,
  output terms_t     dn_data
);

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  logic [7:0] y1_r, y2_r, y3_r;
  term_t [LANES-1:0] term3_r;

  // stall chain, a stage moves when empty or when the next one moves
  assign adv3     = !v3_r || dn_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign up_ready = adv1;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= up_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  // luma rides along
  always_ff @(posedge clk) begin
    if (adv1) y1_r <= luma;
    if (adv2) y2_r <= y1_r;
    if (adv3) y3_r <= y2_r;
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [7:0]              c_sel;
    logic                    neg_s1;
    logic [7:0]              mag_s1;
    logic [PROD_W-1:0]       prod_s1;
    logic [PROD_W-1:0]       prod1_r, prod2_r;
    logic                    neg1_r, neg2_r;
    logic [PROD_W+RECIP_W-1:0] qmul;
    logic [QUOT_W-1:0]       q0_r;
    logic [PROD_W-1:0]       rem;
    logic [QUOT_W-1:0]       qfix;
    term_t                   term_nxt;

    // red and green-v lanes take v, the others take u
    assign c_sel  = (l == LANE_RED || l == LANE_GV) ? chroma_red : chroma_blue;
    assign neg_s1 = c_sel < CHROMA_OFFSET;
    assign mag_s1 = neg_s1 ? (CHROMA_OFFSET - c_sel) : (c_sel - CHROMA_OFFSET);
    assign prod_s1 = PROD_W'(mag_s1) * PROD_W'(TERM_NUM[l]);

    // quotient estimate, at most one below the true value
    assign qmul = prod1_r * TERM_RECIP[l];

    // remainder check fixes the estimate
    assign rem  = prod2_r - PROD_W'(q0_r) * PROD_W'(TERM_DEN[l]);
    assign qfix = (rem >= PROD_W'(TERM_DEN[l])) ? (q0_r + 1'b1) : q0_r;
    assign term_nxt = neg2_r ? -$signed({1'b0, qfix}) : $signed({1'b0, qfix});

    always_ff @(posedge clk) begin
      if (adv1) begin
        prod1_r <= prod_s1;
        neg1_r  <= neg_s1;
      end
      if (adv2) begin
        q0_r    <= qmul[RECIP_SHIFT +: QUOT_W];
        prod2_r <= prod1_r;
        neg2_r  <= neg1_r;
      end
      if (adv3) term3_r[l] <= term_nxt;
    end
  end

  assign dn_valid     = v3_r;
  assign dn_data.luma = y3_r;
  assign dn_data.term = term3_r;

endmodule

>>> hdl/yuv2rgb_mix.sv
// sum and clamp stage followed by the packing stage and output register
module yuv2rgb_mix
  import yuv2rgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  terms_t      up_data,
  input  logic [1:0]  out_format,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [31:0] pixel_word,
  output logic [2:0]  byte_count
);

  function automatic logic [7:0] clamp_pix(input logic signed [10:0] v);
    logic [7:0] res;
    if (v < 0)                           res = 8'd0;
    else if (v > $signed({3'b0, PIX_MAX})) res = PIX_MAX;
    else                                 res = v[7:0];
    return res;
  endfunction

  logic v4_r, v5_r;
  logic adv4, adv5;
  logic signed [10:0] sum_red, sum_green, sum_blue;
  logic signed [10:0] luma_s;
  logic [7:0] red4_r, green4_r, blue4_r;
  logic [7:0] red_r, green_r, blue_r;
  logic [31:0] word_nxt, word_r;
  logic [2:0]  count_nxt, count_r;

  assign adv5     = !v5_r || out_ready;
  assign adv4     = !v4_r || adv5;
  assign up_ready = adv4;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv4) v4_r <= up_valid;
      if (adv5) v5_r <= v4_r;
    end
  end

  // luma plus terms, green subtracts both of its terms
  assign luma_s    = $signed({3'b0, up_data.luma});
  assign sum_red   = luma_s + 11'(up_data.term[LANE_RED]);
  assign sum_green = luma_s - 11'(up_data.term[LANE_GU]) - 11'(up_data.term[LANE_GV]);
  assign sum_blue  = luma_s + 11'(up_data.term[LANE_BLUE]);

  // pack in the selected format, unused code packs as xrgb32
  always_comb begin
    case (out_format)
      FMT_RGB24: begin
        word_nxt  = {8'd0, blue4_r, green4_r, red4_r};
        count_nxt = BYTES_RGB24;
      end
      FMT_RGB565: begin
        word_nxt  = {16'd0, red4_r[7:3], green4_r[7:2], blue4_r[7:3]};
        count_nxt = BYTES_RGB565;
      end
      default: begin
        word_nxt  = {blue4_r, green4_r, red4_r, 8'd0};
        count_nxt = BYTES_XRGB32;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      red4_r   <= clamp_pix(sum_red);
      green4_r <= clamp_pix(sum_green);
      blue4_r  <= clamp_pix(sum_blue);
    end
    if (adv5) begin
      red_r   <= red4_r & PIX_MAX;
      green_r <= green4_r;
      blue_r  <= blue4_r;
      word_r  <= word_nxt;
      count_r <= count_nxt;
    end
  end

  assign out_valid  = v5_r;
  assign red        = red_r;
  assign green      = green_r;
  assign blue       = blue_r;
  assign pixel_word = word_r;
  assign byte_count = count_r;

endmodule

>>> hdl/yuv_to_rgb_pixel_converter.sv
// YUV to RGB pixel converter: one pixel per clock through a five-stage
// pipeline. Each item (luma, blue- and red-difference bytes) gives red, green
// and blue clamped to 0..255 and a packed pixel word in the format set by the
// configuration register (xRGB32, RGB24 or RGB565). Throughput is one item
// per cycle, set by the three-stage chroma divide pipeline and the sum and
// pack stages, all of which advance every cycle unless the output is
// stalled. The format register resets to xRGB32, is always ready, and should
// only be written while no items are in flight.
module yuv_to_rgb_pixel_converter
  import yuv2rgb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  yuv2rgb_in_if.sink           in_chan,
  yuv2rgb_out_if.source        out_chan,
  yuv2rgb_cfg_if.sink          cfg_chan
);

  logic [1:0] fmt_r;
  logic       mid_valid, mid_ready;
  terms_t     mid_data;

  // format register
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_XRGB32;
    end else if (cfg_chan.valid) begin
      fmt_r <= cfg_chan.out_format;
    end
  end

  // chroma terms
  yuv2rgb_chroma u_chroma (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (in_chan.valid),
    .up_ready    (in_chan.ready),
    .luma        (in_chan.luma),
    .chroma_blue (in_chan.chroma_blue),
    .chroma_red  (in_chan.chroma_red),
    .dn_valid    (mid_valid),
    .dn_ready    (mid_ready),
    .dn_data     (mid_data)
  );

  // sum, clamp and pack
  yuv2rgb_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (mid_valid),
    .up_ready   (mid_ready),
    .up_data    (mid_data),
    .out_format (fmt_r),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .red        (out_chan.red),
    .green      (out_chan.green),
    .blue       (out_chan.blue),
    .pixel_word (out_chan.pixel_word),
    .byte_count (out_chan.byte_count)
  );

endmodule

>>> hdl/yuv2rgb_checker.sv
// port-level checks for the converter, bound to the top level
module yuv2rgb_checker
  import yuv2rgb_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic [31:0] pixel_word,
  input logic [2:0]  byte_count
);

  // a stalled item holds its packed word and red component
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_word) && $stable(red))
    else $error("output item changed while stalled");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("output valid after reset");

  // byte count is one of the three formats
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (byte_count == BYTES_XRGB32 || byte_count == BYTES_RGB24 ||
                   byte_count == BYTES_RGB565))
    else $error("bad byte count");

  // packed word agrees with the components
  a_pack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (byte_count == BYTES_XRGB32 && pixel_word == {blue, green, red, 8'd0}) ||
      (byte_count == BYTES_RGB24  && pixel_word == {8'd0, blue, green, red}) ||
      (byte_count == BYTES_RGB565 &&
       pixel_word == {16'd0, red[7:3], green[7:2], blue[7:3]}))
    else $error("packed word does not match components");

endmodule

bind yuv_to_rgb_pixel_converter yuv2rgb_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .red        (out_chan.red),
  .green      (out_chan.green),
  .blue       (out_chan.blue),
  .pixel_word (out_chan.pixel_word),
  .byte_count (out_chan.byte_count)
);
